// ----- src/tfr_pkg.sv -----
// Shared types, codes and arithmetic helpers of the telemetry record framer.
// No dependencies; every other file of the block imports this package.
package tfr_pkg;

  // Record kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    KIND_MON     = 2'd0,
    KIND_BEGIN   = 2'd1,
    KIND_END     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // Frame framing bytes and type codes
  localparam logic [7:0] FrameSof  = 8'hA5;
  localparam logic [7:0] FrameEof  = 8'h5A;
  localparam logic [7:0] TypeMon   = 8'h01;
  localparam logic [7:0] TypeBegin = 8'h02;
  localparam logic [7:0] TypeEnd   = 8'h03;

  // Payload lengths in bytes
  localparam logic [4:0] LenMon   = 5'd10;
  localparam logic [4:0] LenBegin = 5'd8;
  localparam logic [4:0] LenEnd   = 5'd14;
  localparam int unsigned PlBytes = 14;

  // Header bytes before the payload (SOF, type, length, sequence)
  localparam logic [4:0] HdrBytes = 5'd4;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  // Queue depth between front and back
  localparam int unsigned QDepth = 2;

  // Input record
  typedef struct packed {
    logic [1:0]         record_kind;
    logic [31:0]        count_a;
    logic [31:0]        count_b;
    logic [31:0]        count_c;
    logic [7:0]         pass_flag;
    logic [31:0]        freq_hz;
    logic signed [31:0] analog_1;
    logic signed [31:0] analog_2;
    logic signed [31:0] analog_3;
  } rec_t;

  // Output byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frm_t;

  // Classified record waiting for serialization
  typedef struct packed {
    kind_e                      kind;
    logic [PlBytes-1:0][7:0]    pl;
  } entry_t;

  // Saturate an unsigned 32-bit count to 16 bits
  function automatic logic [15:0] sat_u16(input logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  // Multiply a Q16.16 value by ten (shift-add)
  function automatic logic signed [35:0] times_ten(input logic signed [31:0] x);
    logic signed [35:0] w;
    w = 36'(x);
    return (w <<< 3) + (w <<< 1);
  endfunction

  // Divide by 65536 toward zero and saturate to signed 16 bits
  function automatic logic [15:0] sat_q16(input logic signed [35:0] p);
    logic signed [35:0] b;
    logic signed [19:0] q;
    b = p[35] ? (p + 36'sd65535) : p;
    q = 20'(b >>> 16);
    if (q > 20'sd32767) begin
      return 16'h7FFF;
    end else if (q < -20'sd32768) begin
      return 16'h8000;
    end else begin
      return q[15:0];
    end
  endfunction

endpackage

// ----- src/tfr_if.sv -----
// Valid/ready channel interfaces for records in and frame bytes out.
// Depends on tfr_pkg for the payload types.
interface tfr_rec_if;
  import tfr_pkg::*;
  logic valid;
  logic ready;
  rec_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfr_frm_if;
  import tfr_pkg::*;
  logic valid;
  logic ready;
  frm_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tfr_front.sv -----
// Front end: accepts records, drops unknown kinds, scales and saturates the
// fields and builds the little-endian payload. Depends on tfr_pkg.
module tfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_valid_i,
  output logic            rec_ready_o,
  input  tfr_pkg::rec_t   rec_i,
  output logic            push_o,
  input  logic            push_ready_i,
  output tfr_pkg::entry_t entry_o
);
  import tfr_pkg::*;

  logic               s1_v_q;
  kind_e              kind_q;
  logic [15:0]        cnt_a_q, cnt_b_q, cnt_c_q;
  logic [7:0]         pass_q;
  logic [63:0]        fprod;
  logic [63-RecipShift:0] fquo_q;
  logic signed [35:0] p1_q, p2_q, p3_q;
  logic               load;
  logic [15:0]        v1, v2, v3, fsat;

  assign rec_ready_o = !s1_v_q || push_ready_i;
  assign load        = rec_valid_i && rec_ready_o;
  assign fprod       = 64'(rec_i.freq_hz) * 64'(RecipTen);

  // Stage one: valid flag; unknown kinds are taken and dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (rec_ready_o) begin
      s1_v_q <= rec_valid_i && (kind_e'(rec_i.record_kind) != KIND_UNKNOWN);
    end
  end

  // Stage one: products and count saturation
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_e'(rec_i.record_kind);
      cnt_a_q <= sat_u16(rec_i.count_a);
      cnt_b_q <= sat_u16(rec_i.count_b);
      cnt_c_q <= sat_u16(rec_i.count_c);
      pass_q  <= rec_i.pass_flag;
      fquo_q  <= fprod[63:RecipShift];
      p1_q    <= times_ten(rec_i.analog_1);
      p2_q    <= times_ten(rec_i.analog_2);
      p3_q    <= times_ten(rec_i.analog_3);
    end
  end

  // Stage two: truncate, saturate and lay out the payload
  assign v1   = sat_q16(p1_q);
  assign v2   = sat_q16(p2_q);
  assign v3   = sat_q16(p3_q);
  assign fsat = (|fquo_q[63-RecipShift:16]) ? 16'hFFFF : fquo_q[15:0];

  always_comb begin
    entry_o.kind = kind_q;
    entry_o.pl   = '0;
    entry_o.pl[0] = cnt_a_q[7:0];
    entry_o.pl[1] = cnt_a_q[15:8];
    unique case (kind_q)
      KIND_END: begin
        entry_o.pl[2]  = pass_q;
        entry_o.pl[3]  = 8'h00;
        entry_o.pl[4]  = cnt_b_q[7:0];
        entry_o.pl[5]  = cnt_b_q[15:8];
        entry_o.pl[6]  = cnt_c_q[7:0];
        entry_o.pl[7]  = cnt_c_q[15:8];
        entry_o.pl[8]  = v1[7:0];
        entry_o.pl[9]  = v1[15:8];
        entry_o.pl[10] = v2[7:0];
        entry_o.pl[11] = v2[15:8];
        entry_o.pl[12] = v3[7:0];
        entry_o.pl[13] = v3[15:8];
      end
      default: begin
        entry_o.pl[2] = v1[7:0];
        entry_o.pl[3] = v1[15:8];
        entry_o.pl[4] = v2[7:0];
        entry_o.pl[5] = v2[15:8];
        entry_o.pl[6] = v3[7:0];
        entry_o.pl[7] = v3[15:8];
        entry_o.pl[8] = fsat[7:0];
        entry_o.pl[9] = fsat[15:8];
      end
    endcase
  end

  assign push_o = s1_v_q;

endmodule

// ----- src/tfr_queue.sv -----
// Short FIFO of classified records between front and back.
// Depends on tfr_pkg for the entry type and depth.
module tfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  tfr_pkg::entry_t entry_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output tfr_pkg::entry_t entry_o
);
  import tfr_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  entry_t            mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign entry_o      = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- src/tfr_back.sv -----
// Back end: serializes one queued record per frame with header, sequence,
// running XOR checksum and trailer. Depends on tfr_pkg.
module tfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_o,
  input  tfr_pkg::entry_t entry_i,
  output logic            frm_valid_o,
  input  logic            frm_ready_i,
  output tfr_pkg::frm_t   frm_o
);
  import tfr_pkg::*;

  entry_t      cur_q;
  logic        act_q;
  logic [4:0]  idx_q;
  logic [7:0]  chk_q, seq_q;
  logic        ov_q;
  frm_t        out_q;
  logic        adv, emit, is_last;
  logic [4:0]  len, pl_idx;
  logic [7:0]  type_b, byte_w;

  assign adv     = !ov_q || frm_ready_i;
  assign emit    = act_q && adv;

  // Decode the current frame's type and length
  always_comb begin
    unique case (cur_q.kind)
      KIND_BEGIN: begin
        len    = LenBegin;
        type_b = TypeBegin;
      end
      KIND_END: begin
        len    = LenEnd;
        type_b = TypeEnd;
      end
      default: begin
        len    = LenMon;
        type_b = TypeMon;
      end
    endcase
  end

  assign is_last = (idx_q == len + HdrBytes + 5'd1);
  assign pl_idx  = idx_q - HdrBytes;
  assign pop_o   = pop_valid_i && (!act_q || (emit && is_last));

  // Select the byte at the current position
  always_comb begin
    if (idx_q == 5'd0) begin
      byte_w = FrameSof;
    end else if (idx_q == 5'd1) begin
      byte_w = type_b;
    end else if (idx_q == 5'd2) begin
      byte_w = {3'b000, len};
    end else if (idx_q == 5'd3) begin
      byte_w = seq_q;
    end else if (idx_q < len + HdrBytes) begin
      byte_w = cur_q.pl[pl_idx[3:0]];
    end else if (idx_q == len + HdrBytes) begin
      byte_w = chk_q;
    end else begin
      byte_w = FrameEof;
    end
  end

  // Frame control, sequence counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= '0;
      seq_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
        if (is_last) begin
          act_q <= 1'b0;
        end
      end
      if (emit && is_last) begin
        seq_q <= seq_q + 1'b1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (adv) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Load frame, checksum and output byte
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (emit) begin
      chk_q            <= (idx_q == 5'd0) ? byte_w : (chk_q ^ byte_w);
      out_q.frame_byte <= byte_w;
      out_q.frame_last <= is_last;
    end
  end

  assign frm_valid_o = ov_q;
  assign frm_o       = out_q;

endmodule

// ----- src/telemetry_record_framer_top.sv -----
// Top level of the telemetry record framer: front end, record queue, serializer.
// Depends on tfr_pkg, tfr_if, tfr_front, tfr_queue and tfr_back.
//
//   channel  dir  payload                              accepted when
//   rec_i    in   kind, counts, pass flag, freq, Q16   rec_i.valid && rec_i.ready
//   frm_o    out  frame_byte, frame_last               frm_o.valid && frm_o.ready
//
// A record passes the front stage (products registered, then saturation on
// the way into the queue); with the serializer idle it is then loaded from the
// queue into the frame register, and its first byte is registered at the output.
// Bytes go out one per cycle while the output is ready: 16, 14 or 20 bytes per
// frame, so the serializer's byte position sets the sustained rate. Frames
// follow each other with no gap. Reset is asynchronous, active low, and clears
// the sequence counter and all valid state. A stalled output holds its byte;
// the two-entry queue lets the front keep accepting while a frame goes out.
module telemetry_record_framer_top (
  input logic        clk_i,
  input logic        rst_ni,
  tfr_rec_if.sink    rec_i,
  tfr_frm_if.source  frm_o
);
  import tfr_pkg::*;

  logic   push, push_ready, pop_valid, pop;
  entry_t front_entry, queue_entry;

  tfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (rec_i.valid),
    .rec_ready_o  (rec_i.ready),
    .rec_i        (rec_i.data),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (front_entry)
  );

  tfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .entry_i      (front_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .entry_o      (queue_entry)
  );

  tfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .entry_i     (queue_entry),
    .frm_valid_o (frm_o.valid),
    .frm_ready_i (frm_o.ready),
    .frm_o       (frm_o.data)
  );

endmodule

// ----- dv/tfr_frame_check_pkg.sv -----
// Frame predictor and byte checker for the telemetry record framer testbench.
// Depends on tfr_pkg for the record, byte and kind types.
package tfr_frame_check_pkg;
  import tfr_pkg::*;

  class frame_ledger;
    frm_t        expected_bytes[$];
    logic [7:0]  next_seq;
    int unsigned errors;
    int unsigned bytes_checked;
    int unsigned frames;
    int unsigned kind_seen[4];

    function new();
      next_seq      = 8'd0;
      errors        = 0;
      bytes_checked = 0;
      frames        = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    // Clip an unsigned count to 16 bits
    function logic [15:0] clip_count(logic [31:0] v);
      return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Q16.16 times ten, truncated toward zero, clipped to signed 16 bits
    function logic [15:0] scale_tenths(logic signed [31:0] x);
      longint q;
      q = (longint'(x) * 10) / 65536;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    // Append a 16-bit value low byte first
    function void add16(ref logic [7:0] q[$], input logic [15:0] v);
      q.push_back(v[7:0]);
      q.push_back(v[15:8]);
    endfunction

    // Build the frame that an accepted record must produce
    function void note_record(rec_t r);
      logic [7:0] body[$];
      logic [7:0] frame[$];
      logic [7:0] type_code;
      logic [7:0] chk;
      frm_t       f;
      kind_seen[r.record_kind]++;
      case (kind_e'(r.record_kind))
        KIND_MON: begin
          type_code = TypeMon;
          add16(body, clip_count(r.count_a));
          add16(body, scale_tenths(r.analog_1));
          add16(body, scale_tenths(r.analog_2));
          add16(body, scale_tenths(r.analog_3));
          add16(body, clip_count(r.freq_hz / 32'd10));
        end
        KIND_BEGIN: begin
          type_code = TypeBegin;
          add16(body, clip_count(r.count_a));
          add16(body, scale_tenths(r.analog_1));
          add16(body, scale_tenths(r.analog_2));
          add16(body, scale_tenths(r.analog_3));
        end
        KIND_END: begin
          type_code = TypeEnd;
          add16(body, clip_count(r.count_a));
          body.push_back(r.pass_flag);
          body.push_back(8'h00);
          add16(body, clip_count(r.count_b));
          add16(body, clip_count(r.count_c));
          add16(body, scale_tenths(r.analog_1));
          add16(body, scale_tenths(r.analog_2));
          add16(body, scale_tenths(r.analog_3));
        end
        default: begin
          // Unknown kind: no frame, sequence number holds
          return;
        end
      endcase
      frame.push_back(FrameSof);
      frame.push_back(type_code);
      frame.push_back(8'(body.size()));
      frame.push_back(next_seq);
      next_seq = next_seq + 8'd1;
      foreach (body[i]) frame.push_back(body[i]);
      chk = 8'h00;
      foreach (frame[i]) chk = chk ^ frame[i];
      frame.push_back(chk);
      frame.push_back(FrameEof);
      foreach (frame[i]) begin
        f.frame_byte = frame[i];
        f.frame_last = (i == frame.size() - 1);
        expected_bytes.push_back(f);
      end
      frames++;
    endfunction

    // Compare one output transfer against the oldest expected byte
    function void check_byte(frm_t got);
      frm_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte %h (frame_last %b) with nothing pending",
               got.frame_byte, got.frame_last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte mismatch: expected %h, actual %h", want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last mismatch: expected %b, actual %b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Flag bytes that never arrived
    function void close_out();
      if (expected_bytes.size() != 0) begin
        $error("%0d expected frame bytes never arrived", expected_bytes.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
// Top of the telemetry record framer testbench: clock, reset, record driver,
// output stall pattern and byte monitor. Depends on tfr_pkg, tfr_if and tfr_frame_check_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tfr_pkg::*;
  import tfr_frame_check_pkg::*;

  typedef enum int unsigned {
    READY_OPEN,
    READY_RANDOM,
    READY_PERIODIC,
    READY_CHOKED
  } ready_mode_e;

  localparam int unsigned RecordTarget = 330;
  localparam int unsigned DrainEvery   = 110;
  localparam int unsigned TailCycles   = 40;

  logic clk_i;
  logic rst_ni;

  tfr_rec_if rec_if();
  tfr_frm_if frm_if();

  telemetry_record_framer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_if),
    .frm_o  (frm_if)
  );

  frame_ledger ledger = new();
  int unsigned burst_left;
  int unsigned known_sent;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Output stall pattern: pick a random ready mode for each random-length run
  initial begin
    ready_mode_e mode;
    int unsigned left;
    frm_if.ready = 1'b0;
    mode = READY_OPEN;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        READY_OPEN:     frm_if.ready <= 1'b1;
        READY_RANDOM:   frm_if.ready <= ($urandom_range(0, 3) != 0);
        READY_PERIODIC: frm_if.ready <= (left % 3 == 0);
        default:        frm_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && frm_if.valid && frm_if.ready) begin
      ledger.check_byte(frm_if.data);
    end
  end

  function automatic rec_t make_rec(kind_e k, logic [31:0] a, logic [31:0] b,
                                    logic [31:0] c, logic [7:0] pf, logic [31:0] f,
                                    logic [31:0] x1, logic [31:0] x2, logic [31:0] x3);
    rec_t r;
    r.record_kind = k;
    r.count_a     = a;
    r.count_b     = b;
    r.count_c     = c;
    r.pass_flag   = pf;
    r.freq_hz     = f;
    r.analog_1    = x1;
    r.analog_2    = x2;
    r.analog_3    = x3;
    return r;
  endfunction

  // Counts: zero, max, around the 16-bit clip point, in range, or anything
  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(65533, 65538);
      3:       return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Frequency: around the clip point after divide by ten, below ten, in range, max, or anything
  function automatic logic [31:0] rand_freq();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(655340, 655370);
      1:       return $urandom_range(0, 9);
      2:       return $urandom_range(0, 655349);
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Q16.16: near both clip points, near zero, extremes, moderate values, or anything
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 6))
      0:       return $urandom_range(214748355, 214748375);
      1:       return -int'($urandom_range(214754905, 214754930));
      2:       return int'($urandom_range(0, 40000)) - 20000;
      3:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4:       return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_t rand_rec(kind_e k);
    return make_rec(k, rand_count(), rand_count(), rand_count(), 8'($urandom_range(0, 255)),
                    rand_freq(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  // Present one record and hold it until the transfer
  task automatic push_record(input rec_t r);
    rec_if.valid <= 1'b1;
    rec_if.data  <= r;
    do @(posedge clk_i); while (!rec_if.ready);
    ledger.note_record(r);
    if (r.record_kind != KIND_UNKNOWN) known_sent++;
  endtask

  task automatic hold_gap(input int unsigned n);
    rec_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sender bursts: random burst length, then a random gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      hold_gap(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8));
    end
  endtask

  task automatic send_paced(input rec_t r);
    push_record(r);
    pace();
  endtask

  // Stop sending until every expected byte has come out
  task automatic drain();
    rec_if.valid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  // Event begin, a few monitor samples, event end with the same id
  task automatic run_event_sequence();
    rec_t        r;
    logic [31:0] id;
    int unsigned n_mon;
    id = rand_count();
    n_mon = $urandom_range(0, 4);
    r = rand_rec(KIND_BEGIN);
    r.count_a = id;
    send_paced(r);
    repeat (n_mon) send_paced(rand_rec(KIND_MON));
    r = rand_rec(KIND_END);
    r.count_a = id;
    send_paced(r);
  endtask

  initial begin
    int unsigned next_drain;
    rst_ni        = 1'b0;
    rec_if.valid  = 1'b0;
    rec_if.data   = '0;
    burst_left    = 0;
    known_sent    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, clip points, every kind, back to back
    push_record(make_rec(KIND_MON, 0, 0, 0, 0, 0, 0, 0, 0));
    push_record(make_rec(KIND_MON, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    push_record(make_rec(KIND_MON, 65535, 0, 0, 0, 655359,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    push_record(make_rec(KIND_MON, 65536, 0, 0, 0, 655360, 1, -1, 65536));
    push_record(make_rec(KIND_BEGIN, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                         214748364, 214748365, 214748363));
    push_record(make_rec(KIND_BEGIN, 65534, 0, 0, 0, 0,
                         -214754918, -214754919, -214754917));
    push_record(make_rec(KIND_BEGIN, 3, 0, 0, 0, 0, -6553, -6554, -65536));
    push_record(make_rec(KIND_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                         32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    push_record(make_rec(KIND_END, 0, 0, 0, 0, 0, 0, 0, 0));
    push_record(make_rec(KIND_END, 7, 65535, 65536, 8'h5A, 0, 6553, 6554, -1));
    push_record(make_rec(KIND_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_record(make_rec(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0));
    push_record(make_rec(KIND_MON, 12345, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 9,
                         32'h0001_8000, 32'hFFFE_8000, 32'h0000_FFFF));
    push_record(make_rec(KIND_END, 42, 1000, 250, 8'h01, 32'hFFFF_FFFF,
                         32'h0003_0000, 32'h0005_0000, 32'hFFFF_0000));
    push_record(rand_rec(KIND_UNKNOWN));
    push_record(make_rec(KIND_BEGIN, 42, 0, 0, 0, 0, 32'h0000_199A, 32'hFFFF_E666, 0));
    drain();

    // Random: mostly well-formed event sequences, some stray and unknown records
    next_drain = DrainEvery;
    while (known_sent < RecordTarget) begin
      if ($urandom_range(0, 9) < 7) begin
        run_event_sequence();
      end else begin
        send_paced(rand_rec(kind_e'($urandom_range(0, 3))));
      end
      if (known_sent >= next_drain) begin
        drain();
        next_drain += DrainEvery;
      end
    end

    // Wind down: wait out pending bytes, then a short tail
    drain();
    repeat (TailCycles) @(posedge clk_i);
    ledger.close_out();
    $display("Covered %0d monitor, %0d begin, %0d end and %0d unknown records in %0d frames.",
             ledger.kind_seen[KIND_MON], ledger.kind_seen[KIND_BEGIN],
             ledger.kind_seen[KIND_END], ledger.kind_seen[KIND_UNKNOWN], ledger.frames);
    $display("Checked %0d frame bytes; sequence number ended at %0d; %0d errors.",
             ledger.bytes_checked, ledger.next_seq, ledger.errors);
    if (ledger.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- telemetry_record_framer_top.f -----
src/tfr_pkg.sv
src/tfr_if.sv
src/tfr_front.sv
src/tfr_queue.sv
src/tfr_back.sv
src/telemetry_record_framer_top.sv
dv/tfr_frame_check_pkg.sv
dv/testbench.sv
